// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFBA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFBA_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

	localparam int ACTION_W = 2;
	localparam int OWNER_W  = 16;
	localparam int LENGTH_W = 11;
	localparam int PLACE_W  = 10;
	localparam int START_W  = 10;

	// pool size in bytes; the start and place fields are sized to cover it
	localparam int POOL_BYTES = 1024;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC      = 2'd0,
		ACT_FREE_ID    = 2'd1,
		ACT_FREE_START = 2'd2,
		ACT_LOOKUP     = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // latch request, rewind the scan
		logic issue;   // read one table entry, evaluate the previous one
		logic commit;  // update the table, load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic reject;    // incoming request is refused without a scan
		logic finish;    // scan reached its outcome this cycle
		logic out_busy;  // output register holds an untaken transaction
	} status_t;

endpackage

// ===== rtl/ffba_dp.sv =====
// Datapath: block table, entry scan, first-fit candidate search, output register.
module ffba_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ffba_pkg::cmd_t                  cmd,
	output ffba_pkg::status_t               status,
	input  logic [ffba_pkg::ACTION_W-1:0]   action,
	input  logic [ffba_pkg::OWNER_W-1:0]    owner,
	input  logic [ffba_pkg::LENGTH_W-1:0]   length,
	input  logic [ffba_pkg::PLACE_W-1:0]    place,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [ffba_pkg::START_W-1:0]    start_res
);

	localparam int N    = TABLE_ENTRIES;
	localparam int IW   = $clog2(N);
	localparam int CNTW = $clog2(N + 1);
	localparam int PW   = $clog2(ffba_pkg::POOL_BYTES);
	localparam int SUMW = ((PW + 1 > ffba_pkg::LENGTH_W) ? PW + 1 : ffba_pkg::LENGTH_W) + 1;
	localparam int PLW  = (PW > ffba_pkg::PLACE_W) ? PW : ffba_pkg::PLACE_W;
	localparam logic [SUMW-1:0] POOL_C = SUMW'(ffba_pkg::POOL_BYTES);

	// table storage
	logic [ffba_pkg::OWNER_W-1:0]  mem_owner [N];
	logic [PW-1:0]                 mem_start [N];
	logic [ffba_pkg::LENGTH_W-1:0] mem_len   [N];
	logic [N-1:0]                  vld_q;

	// request
	ffba_pkg::act_t                req_action_q;
	logic [ffba_pkg::OWNER_W-1:0]  req_owner_q;
	logic [ffba_pkg::LENGTH_W-1:0] req_len_q;
	logic [ffba_pkg::PLACE_W-1:0]  req_place_q;

	// scan
	logic [IW-1:0]                 rd_idx_q;
	logic                          s1_valid_q;
	logic [ffba_pkg::OWNER_W-1:0]  own_s1;
	logic [PW-1:0]                 st_s1;
	logic [ffba_pkg::LENGTH_W-1:0] len_s1;
	logic                          vld_s1;
	logic [IW-1:0]                 idx_s1;

	logic [SUMW-1:0]               cand_q;
	logic [CNTW-1:0]               clean_q;
	logic                          have_free_q;
	logic [IW-1:0]                 slot_q;

	// outcome
	logic                          res_ok_q;
	logic [ffba_pkg::START_W-1:0]  res_start_q;
	logic [IW-1:0]                 hit_idx_q;

	logic                          out_valid_q;
	logic                          ok_q;
	logic [ffba_pkg::START_W-1:0]  start_res_q;

	ffba_pkg::act_t                in_act;
	logic                          reject_c;
	logic                          eval_en;
	logic [SUMW-1:0]               c_end;
	logic [SUMW-1:0]               e_end;
	logic                          conflict;
	logic                          id_match;
	logic                          start_match;
	logic                          last_entry;
	logic                          slot_hit;
	logic                          have_free_n;
	logic [IW-1:0]                 slot_n;
	logic [CNTW-1:0]               clean_inc;
	logic                          fin;
	logic                          fin_ok;
	logic [ffba_pkg::START_W-1:0]  fin_start;
	logic [IW-1:0]                 fin_idx;
	logic                          jump;

	assign in_act = ffba_pkg::act_t'(action);

	// refusals that need no table access
	always_comb begin
		reject_c = 1'b0;
		if (in_act != ffba_pkg::ACT_FREE_START && owner == '0)
			reject_c = 1'b1;
		if (in_act == ffba_pkg::ACT_ALLOC &&
		    (length == '0 || SUMW'(length) > POOL_C))
			reject_c = 1'b1;
	end

	assign status.reject = reject_c;

	assign eval_en = cmd.issue && s1_valid_q;

	// evaluation of the entry read in the previous cycle
	assign c_end       = cand_q + SUMW'(req_len_q);
	assign e_end       = SUMW'(st_s1) + SUMW'(len_s1);
	assign conflict    = vld_s1 && own_s1 != req_owner_q &&
	                     SUMW'(st_s1) < c_end && cand_q < e_end;
	assign id_match    = vld_s1 && own_s1 == req_owner_q;
	assign start_match = vld_s1 && PLW'(st_s1) == PLW'(req_place_q);
	assign last_entry  = idx_s1 == IW'(N - 1);
	assign slot_hit    = !vld_s1 && (!have_free_q || idx_s1 > slot_q);
	assign have_free_n = have_free_q || !vld_s1;
	assign slot_n      = slot_hit ? idx_s1 : slot_q;
	assign clean_inc   = clean_q + 1'b1;

	always_comb begin
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_start = '0;
		fin_idx   = idx_s1;
		jump      = 1'b0;
		unique case (req_action_q)
			ffba_pkg::ACT_ALLOC: begin
				if (c_end > POOL_C) begin
					fin = 1'b1;
				end else if (conflict) begin
					jump = 1'b1;
				end else if (clean_inc == CNTW'(N)) begin
					fin       = 1'b1;
					fin_ok    = have_free_n;
					fin_start = ffba_pkg::START_W'(cand_q);
					fin_idx   = slot_n;
				end
			end
			ffba_pkg::ACT_FREE_ID: begin
				fin    = id_match || last_entry;
				fin_ok = id_match;
			end
			ffba_pkg::ACT_FREE_START: begin
				fin    = start_match || last_entry;
				fin_ok = start_match;
			end
			ffba_pkg::ACT_LOOKUP: begin
				fin       = id_match || last_entry;
				fin_ok    = id_match;
				fin_start = ffba_pkg::START_W'(st_s1);
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	assign status.finish   = eval_en && fin;
	assign status.out_busy = out_valid_q && !out_ready;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_action_q <= in_act;
			req_owner_q  <= owner;
			req_len_q    <= length;
			req_place_q  <= place;
		end
	end

	// table read port and write port
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			own_s1 <= mem_owner[rd_idx_q];
			st_s1  <= mem_start[rd_idx_q];
			len_s1 <= mem_len[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
		if (cmd.commit && res_ok_q && req_action_q == ffba_pkg::ACT_ALLOC) begin
			mem_owner[hit_idx_q] <= req_owner_q;
			mem_start[hit_idx_q] <= PW'(cand_q);
			mem_len[hit_idx_q]   <= req_len_q;
		end
	end

	// scan control state, entry valid bits, outcome, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			vld_s1      <= 1'b0;
			rd_idx_q    <= '0;
			s1_valid_q  <= 1'b0;
			cand_q      <= '0;
			clean_q     <= '0;
			have_free_q <= 1'b0;
			slot_q      <= '0;
			res_ok_q    <= 1'b0;
			res_start_q <= '0;
			hit_idx_q   <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			start_res_q <= '0;
		end else begin
			if (cmd.start) begin
				rd_idx_q    <= '0;
				s1_valid_q  <= 1'b0;
				cand_q      <= '0;
				clean_q     <= '0;
				have_free_q <= 1'b0;
				res_ok_q    <= 1'b0;
				res_start_q <= '0;
			end
			if (cmd.issue) begin
				rd_idx_q   <= (rd_idx_q == IW'(N - 1)) ? '0 : rd_idx_q + 1'b1;
				vld_s1     <= vld_q[rd_idx_q];
				s1_valid_q <= 1'b1;
			end
			if (eval_en) begin
				have_free_q <= have_free_n;
				slot_q      <= slot_n;
				if (jump) begin
					cand_q  <= e_end;
					clean_q <= '0;
				end else begin
					clean_q <= clean_inc;
				end
				if (fin) begin
					res_ok_q    <= fin_ok;
					res_start_q <= fin_ok ? fin_start : '0;
					hit_idx_q   <= fin_idx;
				end
			end
			if (cmd.commit) begin
				if (res_ok_q) begin
					case (req_action_q) inside
						ffba_pkg::ACT_ALLOC:      vld_q[hit_idx_q] <= 1'b1;
						ffba_pkg::ACT_FREE_ID,
						ffba_pkg::ACT_FREE_START: vld_q[hit_idx_q] <= 1'b0;
						default: ;
					endcase
				end
				out_valid_q <= 1'b1;
				ok_q        <= res_ok_q;
				start_res_q <= res_start_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign start_res = start_res_q;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller: sequences request capture, table scan and commit.
module ffba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ffba_pkg::status_t status,
	output ffba_pkg::cmd_t    cmd
);

	ffba_pkg::state_t state_q;
	ffba_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ffba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_n   = status.reject ? ffba_pkg::ST_COMMIT : ffba_pkg::ST_SCAN;
				end
			end
			ffba_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.finish)
					state_n = ffba_pkg::ST_COMMIT;
			end
			ffba_pkg::ST_COMMIT: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_n    = ffba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = ffba_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: controller plus datapath.
//
// Request channel (in_valid/in_ready): action, owner, length, place. One
// transaction is taken at a time; in_ready is high only while the engine is idle.
// Result channel (out_valid/out_ready): ok, start_res, one per request.
// From request acceptance to result valid:
//   refused requests (owner 0 outside free by start, allocate with zero or
//     oversize length): capture, then commit, with no table scan
//   free / lookup: scan from the first entry to a match or the last entry
//   allocate: scan until the candidate end runs past the pool or all
//     TABLE_ENTRIES entries in a row clear it; a block that forces the
//     candidate start past itself restarts that run
// The block table has a single read port and is scanned one entry per cycle.
// A new request is taken once the previous one is committed, even while its
// result still waits in the output register. If the receiver stalls, the result
// holds in the output register and a finished request waits in commit until
// that register is free. Reset clears the entry valid bits at once: every slot
// reads as free once arst_n rises, with no clearing pass.
module first_fit_block_allocator_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ffba_pkg::ACTION_W-1:0] action,
	input  logic [ffba_pkg::OWNER_W-1:0]  owner,
	input  logic [ffba_pkg::LENGTH_W-1:0] length,
	input  logic [ffba_pkg::PLACE_W-1:0]  place,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [ffba_pkg::START_W-1:0]  start_res
);

	ffba_pkg::cmd_t    cmd;
	ffba_pkg::status_t status;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ffba_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.action    (action),
		.owner     (owner),
		.length    (length),
		.place     (place),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.start_res (start_res)
	);

endmodule

// ===== rtl/ffba_checker.sv =====
// Port-level checker for the allocator top, bound to every instance.
`include "assert_macros.svh"

module ffba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         ok,
	input logic [ffba_pkg::START_W-1:0] start_res
);

	`FFBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(ok) && $stable(start_res), "result changed while stalled")

	`FFBA_ASSERT_NOW(a_fail_zero, out_valid && !ok, start_res == '0,
		"failed transaction carries a nonzero start")

	`FFBA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
		"request taken while engine busy")

	`FFBA_ASSERT_NXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid),
		"result appeared in the cycle after acceptance")

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);
